// ===== design/tgh_pkg.sv =====
// tgh_pkg: shared constants, types and functions of the ternary gradient histogram unit
// used by tgh_front, tgh_hist and ternary_gradient_histogram_unit; no dependencies

package tgh_pkg;

    localparam int IMG_W = 28;
    localparam int IMG_H = 28;
    localparam int COL_W = $clog2(IMG_W);
    localparam int ROW_W = $clog2(IMG_H);

    localparam int PIX_W = 8;
    localparam int THR_W = 8;
    localparam int BIN_W = 6;
    localparam int CNT_W = 13;
    localparam int NBINS = 45;

    localparam int OUT_DATA_W = ((BIN_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - BIN_W - CNT_W;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [THR_W-1:0] HIGH_THR_RST = 8'd170;
    localparam logic [THR_W-1:0] LOW_THR_RST  = 8'd85;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(IMG_W - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(IMG_H - 1);
    localparam logic [ROW_W-1:0] ROW_ONE  = ROW_W'(1);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NBINS - 1);

    localparam logic [BIN_W-1:0] BIN_H_STRIDE = BIN_W'(15);
    localparam logic [BIN_W-1:0] BIN_V_STRIDE = BIN_W'(5);

    // trit in two's complement
    typedef logic [1:0] t_trit;
    localparam t_trit TRIT_ZERO = 2'b00;
    localparam t_trit TRIT_POS  = 2'b01;
    localparam t_trit TRIT_NEG  = 2'b11;

    typedef struct packed {
        t_trit trit;
        t_trit hgrad;
        t_trit vgrad;
    } t_line_word;

    localparam int LINE_W = $bits(t_line_word);

    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin;
    } t_bin_evt;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HIGH_THR = 1'b0,
        CFG_LOW_THR  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        F_WAIT,
        F_RUN,
        F_FLUSH_WR,
        F_FLUSH
    } t_front_state;

    typedef enum logic [1:0] {
        H_CLEAR,
        H_ACC,
        H_DRAIN,
        H_DUMP
    } t_hist_state;

    function automatic t_trit quantize(input logic [PIX_W-1:0] px,
                                       input logic [THR_W-1:0] hi,
                                       input logic [THR_W-1:0] lo);
        t_trit q;
        if (px > hi) begin
            q = TRIT_POS;
        end else if (px < lo) begin
            q = TRIT_NEG;
        end else begin
            q = TRIT_ZERO;
        end
        return q;
    endfunction

    // sign of a minus b
    function automatic t_trit trit_sign(input t_trit a, input t_trit b);
        logic signed [2:0] diff;
        t_trit s;
        diff = $signed({a[1], a}) - $signed({b[1], b});
        if (diff > 3'sd0) begin
            s = TRIT_POS;
        end else if (diff < 3'sd0) begin
            s = TRIT_NEG;
        end else begin
            s = TRIT_ZERO;
        end
        return s;
    endfunction

    function automatic logic [BIN_W-1:0] bin_of(input t_trit h, input t_trit v,
                                                input t_trit hl, input t_trit up);
        logic signed [3:0] d;
        logic [2:0] du;
        logic [1:0] hu;
        logic [1:0] vu;
        d = $signed({{2{h[1]}}, h}) - $signed({{2{hl[1]}}, hl})
            + $signed({{2{v[1]}}, v}) - $signed({{2{up[1]}}, up});
        if (d < -4'sd2) begin
            d = -4'sd2;
        end else if (d > 4'sd2) begin
            d = 4'sd2;
        end
        hu = h + 2'd1;
        vu = v + 2'd1;
        du = d[2:0] + 3'd2;
        return BIN_W'(hu) * BIN_H_STRIDE + BIN_W'(vu) * BIN_V_STRIDE + BIN_W'(du);
    endfunction

endpackage

// ===== design/tgh_ram.sv =====
// tgh_ram: simple dual-port synchronous ram, one write and one registered read per cycle
// a write to the address being read is forwarded; no dependencies

module tgh_ram #(
    parameter int DEPTH = 32,
    parameter int DW    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tgh_front.sv =====
// tgh_front: pixel quantizer, line memory and raster counters; emits one bin event per settled pixel
// depends on tgh_pkg and tgh_ram

module tgh_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_pix_valid,
    output logic                     o_pix_ready,
    input  logic [tgh_pkg::PIX_W-1:0] i_pixel,
    input  logic [tgh_pkg::THR_W-1:0] i_high_thr,
    input  logic [tgh_pkg::THR_W-1:0] i_low_thr,
    output tgh_pkg::t_bin_evt        o_evt,
    output logic                     o_flush_done,
    input  logic                     i_resume
);

    import tgh_pkg::*;

    t_front_state     r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_trit            r_tprev;
    t_trit            r_vprev;
    t_trit            r_hl;

    logic [LINE_W-1:0] rdata;
    t_line_word        rd_word;
    t_line_word        wr_word;
    logic              we;
    logic [COL_W-1:0]  waddr;
    logic              accept;
    logic              first_col;
    logic              last_col;
    logic              last_row;
    t_trit             t_cur;
    t_trit             vnew;
    t_trit             hl;
    t_trit             up;

    tgh_ram #(
        .DEPTH(IMG_W),
        .DW   (LINE_W)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wr_word),
        .i_raddr(n_col),
        .o_rdata(rdata)
    );

    always_comb begin
        rd_word     = t_line_word'(rdata);
        o_pix_ready = (r_state == F_RUN);
        accept      = i_pix_valid && (r_state == F_RUN);
        first_col   = (r_col == '0);
        last_col    = (r_col == LAST_COL);
        last_row    = (r_row == LAST_ROW);
        t_cur       = quantize(i_pixel, i_high_thr, i_low_thr);
        vnew        = trit_sign(t_cur, rd_word.trit);
        hl          = first_col ? TRIT_ZERO : r_hl;
        up          = (r_row == ROW_ONE) ? TRIT_ZERO : rd_word.vgrad;
        // previous column is finished once the current trit is known
        we            = accept || (r_state == F_FLUSH_WR);
        waddr         = first_col ? LAST_COL : (r_col - COL_W'(1));
        wr_word.trit  = r_tprev;
        wr_word.hgrad = first_col ? TRIT_ZERO : trit_sign(t_cur, r_tprev);
        wr_word.vgrad = r_vprev;
    end

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        o_evt        = '0;
        o_flush_done = 1'b0;
        unique case (r_state)
            F_WAIT: begin
                if (i_resume) begin
                    n_state = F_RUN;
                end
            end
            F_RUN: begin
                if (accept) begin
                    o_evt.valid = (r_row != '0);
                    o_evt.bin   = bin_of(rd_word.hgrad, vnew, hl, up);
                    if (last_col) begin
                        n_col = '0;
                        if (last_row) begin
                            n_row   = '0;
                            n_state = F_FLUSH_WR;
                        end else begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            F_FLUSH_WR: begin
                n_state = F_FLUSH;
            end
            F_FLUSH: begin
                // last row settles with no row below
                o_evt.valid = 1'b1;
                o_evt.bin   = bin_of(rd_word.hgrad, TRIT_ZERO, hl, rd_word.vgrad);
                if (last_col) begin
                    n_col        = '0;
                    n_state      = F_WAIT;
                    o_flush_done = 1'b1;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_WAIT;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tprev <= t_cur;
            r_vprev <= vnew;
        end
        if (accept || (r_state == F_FLUSH)) begin
            r_hl <= rd_word.hgrad;
        end
    end

endmodule

// ===== design/tgh_hist.sv =====
// tgh_hist: bin memory with read-modify-write counting, frame-end readout and clear
// depends on tgh_pkg and tgh_ram

module tgh_hist (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tgh_pkg::t_bin_evt        i_evt,
    input  logic                     i_start,
    output logic                     o_done,
    output logic                     o_bin_valid,
    input  logic                     i_bin_ready,
    output logic [tgh_pkg::BIN_W-1:0] o_bin_index,
    output logic [tgh_pkg::CNT_W-1:0] o_bin_count,
    output logic                     o_last_bin
);

    import tgh_pkg::*;

    t_hist_state      r_state, n_state;
    t_bin_evt         r_s1;
    t_bin_evt         r_s2;
    logic [BIN_W-1:0] r_dk, n_dk;
    logic             r_ov;
    logic [BIN_W-1:0] r_obin;
    logic [CNT_W-1:0] r_ocnt;
    logic             r_olast;

    logic             we;
    logic [BIN_W-1:0] waddr;
    logic [CNT_W-1:0] wdata;
    logic [BIN_W-1:0] raddr;
    logic [CNT_W-1:0] rdata;
    logic             adv;
    logic             dk_last;

    tgh_ram #(
        .DEPTH(NBINS),
        .DW   (CNT_W)
    ) u_bins (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        adv     = (r_state == H_DUMP) && (!r_ov || i_bin_ready);
        dk_last = (r_dk == LAST_BIN);
        n_state = r_state;
        n_dk    = r_dk;
        o_done  = 1'b0;
        we      = 1'b0;
        waddr   = r_s2.bin;
        wdata   = rdata + CNT_W'(1);
        raddr   = r_s1.valid ? r_s1.bin : '0;
        unique case (r_state)
            H_CLEAR: begin
                we    = 1'b1;
                waddr = r_dk;
                wdata = '0;
                if (dk_last) begin
                    n_dk    = '0;
                    n_state = H_ACC;
                    o_done  = 1'b1;
                end else begin
                    n_dk = r_dk + BIN_W'(1);
                end
            end
            H_ACC: begin
                we = r_s2.valid;
                if (i_start) begin
                    n_state = H_DRAIN;
                end
            end
            H_DRAIN: begin
                we = r_s2.valid;
                if (!r_s1.valid && !r_s2.valid) begin
                    n_dk    = '0;
                    n_state = H_DUMP;
                end
            end
            H_DUMP: begin
                raddr = r_dk;
                if (adv) begin
                    we    = 1'b1;
                    waddr = r_dk;
                    wdata = '0;
                    if (dk_last) begin
                        n_dk    = '0;
                        n_state = H_ACC;
                        o_done  = 1'b1;
                    end else begin
                        n_dk  = r_dk + BIN_W'(1);
                        raddr = r_dk + BIN_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_CLEAR;
            r_dk    <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dk    <= n_dk;
            r_s1    <= i_evt;
            r_s2    <= r_s1;
            if (adv) begin
                r_ov <= 1'b1;
            end else if (i_bin_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obin  <= r_dk;
            r_ocnt  <= rdata;
            r_olast <= dk_last;
        end
    end

    assign o_bin_valid = r_ov;
    assign o_bin_index = r_obin;
    assign o_bin_count = r_ocnt;
    assign o_last_bin  = r_olast;

endmodule

// ===== design/ternary_gradient_histogram_unit.sv =====
// ternary_gradient_histogram_unit: top level, threshold registers and stream ports
// depends on tgh_pkg, tgh_front and tgh_hist
//
// Pixels of one IMG_W x IMG_H frame enter in raster order on the s_axis channel, one
// item per cycle while s_axis_tready is high. Each pixel is quantized to a trit and
// its horizontal and vertical gradients and divergence select one of 45 histogram
// bins; a pixel is counted one row after it arrives, through a read-modify-write of
// the bin memory. After the final pixel of a frame the input stalls: the line memory
// is finished, the last row is counted, the count pipeline drains, then the 45 bins
// leave on m_axis in order 0..44, one per cycle while m_axis_tready is high, each bin
// cleared as it is read; tlast marks bin 44, and s_axis_tready returns with the last
// bin. A stall on m_axis holds the current bin and pauses the readout.
// After reset the thresholds are 170 and 85, the position is row 0, column 0, and a
// clearing pass zeroes the bin memory before the first pixel is taken. Thresholds
// are to be written through i_cfg_we / i_cfg_addr / i_cfg_wdata between frames; the
// block itself does not enforce this.

module ternary_gradient_histogram_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tgh_pkg::PIX_W-1:0]      s_axis_tdata,   // pixel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tgh_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // bin_index, bin_count, zero pad
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [tgh_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tgh_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import tgh_pkg::*;

    logic [THR_W-1:0] r_high_thr;
    logic [THR_W-1:0] r_low_thr;

    t_bin_evt         evt;
    logic             flush_done;
    logic             hist_done;
    logic [BIN_W-1:0] bin_index;
    logic [CNT_W-1:0] bin_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thr <= HIGH_THR_RST;
            r_low_thr  <= LOW_THR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_HIGH_THR: r_high_thr <= i_cfg_wdata;
                CFG_LOW_THR:  r_low_thr  <= i_cfg_wdata;
            endcase
        end
    end

    tgh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (s_axis_tvalid),
        .o_pix_ready (s_axis_tready),
        .i_pixel     (s_axis_tdata),
        .i_high_thr  (r_high_thr),
        .i_low_thr   (r_low_thr),
        .o_evt       (evt),
        .o_flush_done(flush_done),
        .i_resume    (hist_done)
    );

    tgh_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .i_start    (flush_done),
        .o_done     (hist_done),
        .o_bin_valid(m_axis_tvalid),
        .i_bin_ready(m_axis_tready),
        .o_bin_index(bin_index),
        .o_bin_count(bin_count),
        .o_last_bin (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, bin_count, bin_index};

endmodule
